/* sv/assembler_token_lexer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the token lexer
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSEMBLER_TOKEN_LEXER_ASSERT_SVH
`define ASSEMBLER_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define ATL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication
`define ATL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

/* sv/atl_pkg.sv */
// ---------------------------------------------------------------------------
// atl_pkg
// Token kinds, error causes, scan modes and the token record shared by the
// lexer front end, queue and emitter.
// ---------------------------------------------------------------------------
package atl_pkg;

  localparam int LenW = 7;
  localparam logic [62:0] ValueMax = {63{1'b1}};

  localparam logic [7:0] ChrX     = 8'h78;
  localparam logic [7:0] ChrG     = 8'h67;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrUnder = 8'h5f;
  localparam logic [7:0] ChrNl    = 8'h0a;
  localparam logic [7:0] ChrComma = 8'h2c;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0d;
  localparam logic [7:0] ChrFf    = 8'h0c;
  localparam logic [7:0] ChrLa    = 8'h61;
  localparam logic [7:0] ChrUa    = 8'h41;

  localparam logic [23:0] WordMov  = 24'h766f6d;
  localparam logic [31:0] WordZero = 32'h6f72657a;
  localparam logic [23:0] WordHlt  = 24'h746c68;
  localparam logic [23:0] WordSrr  = 24'h727273;

  typedef enum logic [3:0] {
    KIND_NEWLINE = 4'd0,
    KIND_COMMA   = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_NUMBER  = 4'd3,
    KIND_REG     = 4'd4,
    KIND_MOV     = 4'd5,
    KIND_ZERO    = 4'd6,
    KIND_HLT     = 4'd7,
    KIND_SRR     = 4'd8,
    KIND_ERROR   = 4'd9,
    KIND_END     = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_BAD_CHAR = 2'd1,
    CAUSE_TOO_LONG = 2'd2,
    CAUSE_NO_HEX   = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_DEC    = 3'd2,
    MODE_HEXPRE = 3'd3,
    MODE_HEX    = 3'd4
  } mode_e;

  typedef struct packed {
    logic             has_tok;
    kind_e            tok_kind;
    logic [3:0]       reg_idx;
    logic [62:0]      value;
    logic             sat;
    logic [LenW-1:0]  len;
    cause_e           cause;
    logic             has_simple;
    kind_e            simple_kind;
    cause_e           simple_cause;
  } tok_rec_t;

endpackage

/* sv/atl_fifo.sv */
// ---------------------------------------------------------------------------
// atl_fifo
// Two-entry queue between the lexer front end and the token emitter.
// ---------------------------------------------------------------------------
module atl_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* sv/atl_front.sv */
// ---------------------------------------------------------------------------
// atl_front
// Byte classifier and scan state: builds identifiers and numbers and hands
// finished tokens to the queue as one record per transaction.
// ---------------------------------------------------------------------------
module atl_front import atl_pkg::*; #(
  parameter int MaxIdentChars   = 32,
  parameter int MaxNumberDigits = 23
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic [7:0]                 byte_i,
  input  logic                       eoi_i,
  output logic                       push_o,
  output tok_rec_t                   rec_o,
  output logic [MaxIdentChars*8-1:0] chars_o
);

  localparam int CntW = $clog2(MaxIdentChars + 2);
  localparam int IdxW = $clog2(MaxIdentChars);
  localparam int DigW = $clog2(MaxNumberDigits + 2);

  mode_e                      mode_q, mode_d;
  logic [MaxIdentChars*8-1:0] chars_q, chars_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [62:0]                acc_q, acc_d;
  logic [DigW-1:0]            dc_q, dc_d;
  logic                       stop_q, stop_d;
  logic                       sat_q, sat_d;
  logic                       reg_ok_q, reg_ok_d;
  logic [4:0]                 regv_q, regv_d;

  logic       is_alpha, is_digit, is_word, is_space, is_hex, is_x;
  logic [3:0] hv;
  logic       cont;
  mode_e      cont_mode, start_mode;
  logic [66:0] prod10;
  logic        ovf10, ovf16;
  logic [7:0]  regv_next;
  tok_rec_t    fin;

  assign is_alpha = (byte_i inside {[8'h61:8'h7a]}) || (byte_i inside {[8'h41:8'h5a]});
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign is_word  = is_alpha || is_digit || (byte_i == ChrUnder);
  assign is_space = (byte_i == ChrSpace) || (byte_i == ChrTab) ||
                    (byte_i == ChrCr) || (byte_i == ChrFf);
  assign is_hex   = is_digit || (byte_i inside {[8'h61:8'h66]}) ||
                    (byte_i inside {[8'h41:8'h46]});
  assign is_x     = byte_i == ChrX;

  always_comb begin
    if (is_digit) begin
      hv = 4'(byte_i - ChrZero);
    end else if (byte_i inside {[8'h61:8'h66]}) begin
      hv = 4'(byte_i - ChrLa + 8'd10);
    end else begin
      hv = 4'(byte_i - ChrUa + 8'd10);
    end
  end

  assign prod10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 67'(hv);
  assign ovf10  = |prod10[66:63];
  assign ovf16  = |acc_q[62:59];
  assign regv_next = 8'(regv_q) * 8'd10 + 8'(hv);

  always_comb begin
    case (mode_q)
      MODE_IDENT:  cont = is_word;
      MODE_DEC:    cont = (dc_q == '0 && is_x) || is_hex;
      MODE_HEXPRE,
      MODE_HEX:    cont = is_hex;
      default:     cont = 1'b0;
    endcase
  end

  always_comb begin
    if (mode_q == MODE_DEC && dc_q == '0 && is_x) begin
      cont_mode = MODE_HEXPRE;
    end else if (mode_q == MODE_HEXPRE || mode_q == MODE_HEX) begin
      cont_mode = MODE_HEX;
    end else begin
      cont_mode = mode_q;
    end
    if (is_alpha || byte_i == ChrUnder) begin
      start_mode = MODE_IDENT;
    end else if (is_digit) begin
      start_mode = MODE_DEC;
    end else begin
      start_mode = MODE_IDLE;
    end
  end

  // next scan mode
  always_comb begin
    mode_d = mode_q;
    if (acc_i) begin
      if (eoi_i) begin
        mode_d = MODE_IDLE;
      end else if (cont) begin
        mode_d = cont_mode;
      end else begin
        mode_d = start_mode;
      end
    end
  end

  // token that the pending scan state finishes
  always_comb begin
    fin = '0;
    fin.tok_kind = KIND_NEWLINE;
    fin.cause    = CAUSE_NONE;
    fin.simple_kind  = KIND_NEWLINE;
    fin.simple_cause = CAUSE_NONE;
    case (mode_q)
      MODE_IDENT: begin
        fin.has_tok = 1'b1;
        if (cnt_q > CntW'(MaxIdentChars)) begin
          fin.tok_kind = KIND_ERROR;
          fin.cause    = CAUSE_TOO_LONG;
        end else if (cnt_q == CntW'(3) && chars_q[23:0] == WordMov) begin
          fin.tok_kind = KIND_MOV;
        end else if (cnt_q == CntW'(4) && chars_q[31:0] == WordZero) begin
          fin.tok_kind = KIND_ZERO;
        end else if (cnt_q == CntW'(3) && chars_q[23:0] == WordHlt) begin
          fin.tok_kind = KIND_HLT;
        end else if (cnt_q == CntW'(3) && chars_q[23:0] == WordSrr) begin
          fin.tok_kind = KIND_SRR;
        end else if (chars_q[7:0] == ChrG && reg_ok_q && cnt_q >= CntW'(2) &&
                     ((regv_q >= 5'd1 && regv_q <= 5'd15) ||
                      (regv_q == 5'd0 && cnt_q == CntW'(2)))) begin
          fin.tok_kind = KIND_REG;
          fin.reg_idx  = regv_q[3:0];
        end else begin
          fin.tok_kind = KIND_IDENT;
          fin.len      = LenW'(cnt_q);
        end
      end
      MODE_DEC,
      MODE_HEX: begin
        fin.has_tok = 1'b1;
        if (dc_q > DigW'(MaxNumberDigits)) begin
          fin.tok_kind = KIND_ERROR;
          fin.cause    = CAUSE_TOO_LONG;
        end else begin
          fin.tok_kind = KIND_NUMBER;
          fin.value    = acc_q;
          fin.sat      = sat_q;
        end
      end
      MODE_HEXPRE: begin
        fin.has_tok  = 1'b1;
        fin.tok_kind = KIND_ERROR;
        fin.cause    = CAUSE_NO_HEX;
      end
      default: begin
        fin.has_tok = 1'b0;
      end
    endcase
  end

  // scan datapath and record output
  always_comb begin
    chars_d  = chars_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    dc_d     = dc_q;
    stop_d   = stop_q;
    sat_d    = sat_q;
    reg_ok_d = reg_ok_q;
    regv_d   = regv_q;
    rec_o    = fin;
    push_o   = 1'b0;

    if (acc_i && !eoi_i && cont) begin
      case (mode_q)
        MODE_IDENT: begin
          if (cnt_q < CntW'(MaxIdentChars)) begin
            chars_d[cnt_q[IdxW-1:0]*8 +: 8] = byte_i;
          end
          if (cnt_q <= CntW'(MaxIdentChars)) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (!is_digit) begin
            reg_ok_d = 1'b0;
          end else begin
            regv_d = (regv_next > 8'd16) ? 5'd16 : regv_next[4:0];
          end
        end
        MODE_DEC: begin
          if (is_hex) begin
            if (dc_q <= DigW'(MaxNumberDigits)) begin
              dc_d = dc_q + DigW'(1);
            end
            if (!is_digit) begin
              stop_d = 1'b1;
            end else if (!stop_q) begin
              if (sat_q || ovf10) begin
                acc_d = ValueMax;
                sat_d = 1'b1;
              end else begin
                acc_d = prod10[62:0];
              end
            end
          end
        end
        default: begin
          if (dc_q <= DigW'(MaxNumberDigits)) begin
            dc_d = dc_q + DigW'(1);
          end
          if (sat_q || ovf16) begin
            acc_d = ValueMax;
            sat_d = 1'b1;
          end else begin
            acc_d = {acc_q[58:0], hv};
          end
        end
      endcase
    end else if (acc_i) begin
      cnt_d  = '0;
      acc_d  = '0;
      dc_d   = '0;
      stop_d = 1'b0;
      sat_d  = 1'b0;
      if (eoi_i) begin
        rec_o.has_simple = 1'b1;
        rec_o.simple_kind = KIND_END;
      end else if (is_alpha || byte_i == ChrUnder) begin
        chars_d[7:0] = byte_i;
        cnt_d    = CntW'(1);
        reg_ok_d = 1'b1;
        regv_d   = '0;
      end else if (is_digit) begin
        acc_d = 63'(hv);
        dc_d  = (byte_i == ChrZero) ? '0 : DigW'(1);
      end else if (byte_i == ChrNl) begin
        rec_o.has_simple  = 1'b1;
        rec_o.simple_kind = KIND_NEWLINE;
      end else if (byte_i == ChrComma) begin
        rec_o.has_simple  = 1'b1;
        rec_o.simple_kind = KIND_COMMA;
      end else if (!is_space) begin
        rec_o.has_simple   = 1'b1;
        rec_o.simple_kind  = KIND_ERROR;
        rec_o.simple_cause = CAUSE_BAD_CHAR;
      end
      push_o = rec_o.has_tok || rec_o.has_simple;
    end
  end

  assign chars_o = chars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      cnt_q    <= '0;
      acc_q    <= '0;
      dc_q     <= '0;
      stop_q   <= 1'b0;
      sat_q    <= 1'b0;
      reg_ok_q <= 1'b0;
      regv_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      dc_q     <= dc_d;
      stop_q   <= stop_d;
      sat_q    <= sat_d;
      reg_ok_q <= reg_ok_d;
      regv_q   <= regv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

/* sv/atl_back.sv */
// ---------------------------------------------------------------------------
// atl_back
// Token emitter: expands one queued record into its results, splitting
// identifiers into 8-character chunks, into a registered output stage.
// ---------------------------------------------------------------------------
module atl_back import atl_pkg::*; #(
  parameter int MaxIdentChars = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rec_valid_i,
  input  tok_rec_t                   rec_i,
  input  logic [MaxIdentChars*8-1:0] chars_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output kind_e                      kind_o,
  output logic [3:0]                 reg_idx_o,
  output logic [62:0]                value_o,
  output logic                       sat_o,
  output logic [63:0]                chunk_o,
  output logic [5:0]                 len_o,
  output cause_e                     cause_o,
  output logic                       last_o
);

  localparam int NChunks = (MaxIdentChars + 7) / 8;
  localparam int ChW     = (NChunks > 1) ? $clog2(NChunks) : 1;

  logic [NChunks*64-1:0] chars_pad;
  logic [63:0]           chunks [NChunks];
  logic [63:0]           chunk_sel;

  logic            phase_q, phase_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic            vld_q, vld_d;
  kind_e           kind_q, kind_d;
  logic [3:0]      reg_q, reg_d;
  logic [62:0]     val_q, val_d;
  logic            sat_q, sat_d;
  logic [63:0]     chk_q, chk_d;
  logic [5:0]      len_q, len_d;
  cause_e          cause_q, cause_d;
  logic            last_q, last_d;

  logic            load;
  logic            chunk_last;
  logic [LenW-1:0] len_m1;

  assign chars_pad = (NChunks*64)'(chars_i);

  always_comb begin
    for (int i = 0; i < NChunks; i++) begin
      chunks[i] = chars_pad[i*64 +: 64];
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      chunk_sel[j*8 +: 8] = (LenW'({ch_q, 3'(j)}) < rec_i.len) ?
                            chunks[ch_q][j*8 +: 8] : 8'h00;
    end
  end

  assign len_m1     = rec_i.len - LenW'(1);
  assign chunk_last = ch_q >= ChW'(len_m1 >> 3);
  assign load       = rec_valid_i && (!vld_q || out_ready_i);

  always_comb begin
    phase_d = phase_q;
    ch_d    = ch_q;
    pop_o   = 1'b0;
    vld_d   = vld_q && !out_ready_i;
    kind_d  = kind_q;
    reg_d   = reg_q;
    val_d   = val_q;
    sat_d   = sat_q;
    chk_d   = chk_q;
    len_d   = len_q;
    cause_d = cause_q;
    last_d  = last_q;
    if (load) begin
      vld_d = 1'b1;
      reg_d = '0;
      val_d = '0;
      sat_d = 1'b0;
      chk_d = '0;
      len_d = '0;
      last_d = 1'b1;
      if (rec_i.has_tok && !phase_q) begin
        kind_d  = rec_i.tok_kind;
        reg_d   = rec_i.reg_idx;
        val_d   = rec_i.value;
        sat_d   = rec_i.sat;
        cause_d = rec_i.cause;
        if (rec_i.tok_kind == KIND_IDENT) begin
          chk_d  = chunk_sel;
          len_d  = rec_i.len[5:0];
          last_d = chunk_last;
        end
        if (rec_i.tok_kind != KIND_IDENT || chunk_last) begin
          ch_d = '0;
          if (rec_i.has_simple) begin
            phase_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          ch_d = ch_q + ChW'(1);
        end
      end else begin
        kind_d  = rec_i.simple_kind;
        cause_d = rec_i.simple_cause;
        pop_o   = 1'b1;
        phase_d = 1'b0;
        ch_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      ch_q    <= '0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ch_q    <= ch_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    reg_q   <= reg_d;
    val_q   <= val_d;
    sat_q   <= sat_d;
    chk_q   <= chk_d;
    len_q   <= len_d;
    cause_q <= cause_d;
    last_q  <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign reg_idx_o   = reg_q;
  assign value_o     = val_q;
  assign sat_o       = sat_q;
  assign chunk_o     = chk_q;
  assign len_o       = len_q;
  assign cause_o     = cause_q;
  assign last_o      = last_q;

endmodule

/* sv/assembler_token_lexer.sv */
// ---------------------------------------------------------------------------
// assembler_token_lexer
// Byte-stream tokenizer for a small assembler: keywords, registers,
// identifier chunks, saturating decimal/hex numbers and error tokens.
// ---------------------------------------------------------------------------
//  channel   dir  tdata                       tuser          tlast
//  s_axis    in   byte_value                  end_of_input   -
//  m_axis    out  reg/value/sat/chunk/len/err token_kind     last_of_run
//
//  One byte per cycle in while the queue has room; one result per cycle out
//  of the output register while the sink is ready. A record holds a finished
//  token plus one single token, so an identifier of n chars gives ceil(n/8)
//  results plus one when a separator token follows. The two-entry queue sets
//  how long input flows while output stalls. Reset leaves the scan idle.
// ---------------------------------------------------------------------------
module assembler_token_lexer import atl_pkg::*; #(
  parameter int MaxIdentChars   = 32,
  parameter int MaxNumberDigits = 23
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]   s_axis_tuser,   // [0] end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] register_index, [66:4] number_value, [67] number_saturated,
  // [131:68] ident_chunk, [137:132] ident_length, [139:138] error_cause
  output logic [143:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,   // [3:0] token_kind
  output logic         m_axis_tlast
);

  localparam int CharsW = MaxIdentChars * 8;
  localparam int RecW   = $bits(tok_rec_t);

  logic                  acc;
  logic                  push, pop, full, empty;
  tok_rec_t              rec_in, rec_out;
  logic [CharsW-1:0]     chars_in, chars_out;
  logic [CharsW+RecW-1:0] q_rdata;
  kind_e                 kind;
  logic [3:0]            reg_idx;
  logic [62:0]           value;
  logic                  sat;
  logic [63:0]           chunk;
  logic [5:0]            len;
  cause_e                cause;

  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  atl_front #(
    .MaxIdentChars  (MaxIdentChars),
    .MaxNumberDigits(MaxNumberDigits)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (s_axis_tdata),
    .eoi_i  (s_axis_tuser[0]),
    .push_o (push),
    .rec_o  (rec_in),
    .chars_o(chars_in)
  );

  atl_fifo #(
    .Width(CharsW + RecW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({chars_in, rec_in}),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (full),
    .empty_o(empty)
  );

  assign rec_out   = q_rdata[RecW-1:0];
  assign chars_out = q_rdata[CharsW+RecW-1:RecW];

  atl_back #(
    .MaxIdentChars(MaxIdentChars)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(!empty),
    .rec_i      (rec_out),
    .chars_i    (chars_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .kind_o     (kind),
    .reg_idx_o  (reg_idx),
    .value_o    (value),
    .sat_o      (sat),
    .chunk_o    (chunk),
    .len_o      (len),
    .cause_o    (cause),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {4'b0, cause, len, chunk, sat, value, reg_idx};

endmodule

/* sv/atl_checker.sv */
// ---------------------------------------------------------------------------
// atl_checker
// Port-level checks on the lexer result stream.
// ---------------------------------------------------------------------------
`include "assembler_token_lexer_assert.svh"

module atl_checker import atl_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [3:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  `ATL_ASSERT_SAME(a_single_last, m_axis_tvalid && m_axis_tuser != KIND_IDENT, m_axis_tlast)
  `ATL_ASSERT_SAME(a_value_only_number, m_axis_tvalid && m_axis_tuser != KIND_NUMBER, m_axis_tdata[67:4] == '0)
  `ATL_ASSERT_SAME(a_ident_len, m_axis_tvalid && m_axis_tuser == KIND_IDENT, m_axis_tdata[137:132] != 6'd0)
  `ATL_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind assembler_token_lexer atl_checker u_atl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Token lexer testbench. Feeds source bytes over the input stream and
// predicts each token with an in-bench scanner model. Every output
// transaction is checked field by field against the oldest pending token.
// Directed sequences cover keywords, registers, number forms, error
// causes and end of input. Random sequences mix well-formed tokens with
// noise. Both stream sides idle at random, with one long output hold-off
// and full drains of pending tokens.
// ---------------------------------------------------------------------------
module tb_top;
  import atl_pkg::*;

  localparam int IdMax  = 32;
  localparam int DigMax = 23;
  localparam logic [63:0] VMax = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    kind_e       kind;
    logic [3:0]  ridx;
    logic [62:0] val;
    logic        sat;
    logic [63:0] chunk;
    logic [5:0]  len;
    cause_e      cause;
    logic        last;
  } token_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] byte_value
  logic [0:0]   s_axis_tuser;   // [0] end_of_input
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [3:0] register_index, [66:4] number_value, [67] number_saturated,
  // [131:68] ident_chunk, [137:132] ident_length, [139:138] error_cause
  logic [143:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;   // [3:0] token_kind
  logic         m_axis_tlast;

  token_t      token_q[$];
  int          errors;
  int          burst_left;
  int unsigned cyc;
  int unsigned hold_end;
  int          ready_mode;

  mode_e       scan_mode;
  logic [7:0]  id_chars[IdMax];
  int          id_count;
  logic [63:0] accum;
  int          digits;
  logic        stopped;
  logic        sat_flag;

  assembler_token_lexer i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // scanner model
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (is_digit(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic push_token(kind_e k, logic [3:0] r, logic [62:0] v, logic s,
                            logic [63:0] ch, logic [5:0] n, cause_e ca, logic l);
    token_t t;
    t.kind = k; t.ridx = r; t.val = v; t.sat = s;
    t.chunk = ch; t.len = n; t.cause = ca; t.last = l;
    token_q.push_back(t);
  endtask

  task automatic push_single(kind_e k, cause_e ca);
    push_token(k, '0, '0, 1'b0, '0, '0, ca, 1'b1);
  endtask

  function automatic bit word_is(string w);
    if (id_count != w.len()) return 0;
    for (int i = 0; i < w.len(); i++) if (id_chars[i] != w[i]) return 0;
    return 1;
  endfunction

  task automatic finish_ident();
    int rv;
    bit all_dig;
    logic [63:0] ch;
    rv = 0;
    all_dig = id_count >= 2;
    if (id_count > IdMax) begin
      push_single(KIND_ERROR, CAUSE_TOO_LONG);
      return;
    end
    if (word_is("mov")) begin push_single(KIND_MOV, CAUSE_NONE); return; end
    if (word_is("zero")) begin push_single(KIND_ZERO, CAUSE_NONE); return; end
    if (word_is("hlt")) begin push_single(KIND_HLT, CAUSE_NONE); return; end
    if (word_is("srr")) begin push_single(KIND_SRR, CAUSE_NONE); return; end
    if (id_chars[0] == ChrG) begin
      for (int i = 1; i < id_count; i++) begin
        if (!is_digit(id_chars[i])) begin
          all_dig = 0;
          break;
        end
        rv = rv * 10 + int'(id_chars[i] - "0");
        if (rv > 16) rv = 16;
      end
      if (all_dig && ((rv >= 1 && rv <= 15) || (rv == 0 && id_count == 2))) begin
        push_token(KIND_REG, rv[3:0], '0, 1'b0, '0, '0, CAUSE_NONE, 1'b1);
        return;
      end
    end
    for (int i = 0; i < id_count; i += 8) begin
      ch = '0;
      for (int j = 0; j < 8 && i + j < id_count; j++) ch[8*j +: 8] = id_chars[i+j];
      push_token(KIND_IDENT, '0, '0, 1'b0, ch, id_count[5:0], CAUSE_NONE,
                 i + 8 >= id_count);
    end
  endtask

  task automatic finish_pending();
    case (scan_mode)
      MODE_IDENT: finish_ident();
      MODE_DEC, MODE_HEX: begin
        if (digits > DigMax) push_single(KIND_ERROR, CAUSE_TOO_LONG);
        else push_token(KIND_NUMBER, '0, accum[62:0], sat_flag, '0, '0, CAUSE_NONE, 1'b1);
      end
      MODE_HEXPRE: push_single(KIND_ERROR, CAUSE_NO_HEX);
      default: ;
    endcase
    scan_mode = MODE_IDLE;
    id_count = 0;
    accum = '0;
    digits = 0;
    stopped = 0;
    sat_flag = 0;
  endtask

  task automatic add_digit(int base, int d);
    if (sat_flag || accum > (VMax - 64'(d)) / 64'(base)) begin
      accum = VMax;
      sat_flag = 1;
    end else begin
      accum = accum * 64'(base) + 64'(d);
    end
  endtask

  task automatic count_digit();
    if (digits <= DigMax) digits++;
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eoi);
    int hv;
    hv = hex_val(c);
    if (eoi) begin
      finish_pending();
      push_single(KIND_END, CAUSE_NONE);
      return;
    end
    case (scan_mode)
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == ChrUnder) begin
          if (id_count < IdMax) id_chars[id_count] = c;
          if (id_count <= IdMax) id_count++;
          return;
        end
      end
      MODE_DEC: begin
        if (digits == 0 && c == ChrX) begin
          scan_mode = MODE_HEXPRE;
          return;
        end
        if (hv >= 0) begin
          count_digit();
          if (!is_digit(c)) stopped = 1;
          else if (!stopped) add_digit(10, hv);
          return;
        end
      end
      MODE_HEXPRE, MODE_HEX: begin
        if (hv >= 0) begin
          scan_mode = MODE_HEX;
          count_digit();
          add_digit(16, hv);
          return;
        end
      end
      default: ;
    endcase
    finish_pending();
    if (c == ChrSpace || c == ChrTab || c == ChrCr || c == ChrFf) return;
    if (c == ChrNl) push_single(KIND_NEWLINE, CAUSE_NONE);
    else if (c == ChrComma) push_single(KIND_COMMA, CAUSE_NONE);
    else if (is_alpha(c) || c == ChrUnder) begin
      scan_mode = MODE_IDENT;
      id_chars[0] = c;
      id_count = 1;
    end else if (is_digit(c)) begin
      scan_mode = MODE_DEC;
      accum = 64'(c - "0");
      digits = (c == ChrZero) ? 0 : 1;
    end else push_single(KIND_ERROR, CAUSE_BAD_CHAR);
  endtask

  // stimulus
  task automatic send_byte(logic [7:0] c, logic eoi);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tokens(c, eoi);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic send_random_token();
    int n;
    case ($urandom_range(0, 11))
      0: send_text("mov");
      1: send_text("zero");
      2: send_text("hlt");
      3: send_text("srr");
      4: send_text($sformatf("g%0d", $urandom_range(0, 20)));
      5: send_text($sformatf("g0%0d", $urandom_range(0, 99)));
      6, 7: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: send_byte((i == 0) ? ChrUnder : 8'($urandom_range(48, 57)), 1'b0);
            1: send_byte(8'($urandom_range(65, 90)), 1'b0);
            default: send_byte(8'($urandom_range(97, 122)), 1'b0);
          endcase
        end
      end
      8: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(97, 102))
                                                : 8'($urandom_range(48, 57)), 1'b0);
      end
      9: begin
        send_text("0x");
        n = $urandom_range(0, 20);
        for (int i = 0; i < n; i++) send_text($sformatf("%h", 4'($urandom_range(0, 15))));
      end
      10: send_byte(8'($urandom_range(0, 255)), 1'b0);
      default: send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                     : 8'($urandom_range(128, 255)), 1'b0);
    endcase
    case ($urandom_range(0, 7))
      0: send_byte(ChrComma, 1'b0);
      1: send_byte(ChrNl, 1'b0);
      2: send_byte(ChrTab, 1'b0);
      3: ;
      default: send_byte(ChrSpace, 1'b0);
    endcase
  endtask

  task automatic wait_drained();
    idle_input();
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_keywords_and_registers();
    send_text("mov zero,hlt\tsrr\r\fg0 g15 g16 g00 g01 g1abc G1 _");
    send_end();
  endtask

  task automatic test_numbers();
    send_text("0 0x,0xg 0x7fffffffffffffff 0x8000000000000000 05 0a 12ab34\n");
    send_text("99999999999999999999 123456789012345678901234 0");
    send_end();
    send_text("0x");
    send_end();
  endtask

  task automatic test_errors_and_long_idents();
    send_byte(8'h00, 1'b0);
    send_byte(8'h0b, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("abcdefghijklmnopqrstuvwxyz_ABCDEF abcdefghijklmnopqrstuvwxyz_ABCDEFG ");
    send_text("Zq_9abcdefgh");
    send_end();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 12; i++) begin
      send_random_token();
      if ($urandom_range(0, 40) == 0) send_end();
    end
    send_end();
  endtask

  task automatic test_output_hold_off();
    hold_end = cyc + 150;
    for (int i = 0; i < 4; i++) send_text("abcdefghijklmnopq,");
    send_end();
  endtask

  task automatic test_after_drain();
    wait_drained();
    for (int i = 0; i < 6; i++) send_random_token();
    send_end();
  endtask

  // output checking and ready pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc <= 0;
      m_axis_tready <= 1'b0;
      ready_mode <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc % 64 == 0) ready_mode <= $urandom_range(0, 2);
      if (cyc < hold_end) m_axis_tready <= 1'b0;
      else if (ready_mode == 0) m_axis_tready <= 1'b1;
      else if (ready_mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 1) != 0);
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, actual kind %0d", $time, m_axis_tuser);
          errors++;
        end else begin
          token_t t;
          t = token_q.pop_front();
          if ({m_axis_tuser, m_axis_tdata[139:0], m_axis_tlast} !==
              {t.kind, t.cause, t.len, t.chunk, t.sat, t.val, t.ridx, t.last}) begin
            $display("%0t: mismatch expected kind %0d reg %0d val %h sat %b chunk %h len %0d cause %0d last %b",
                     $time, t.kind, t.ridx, t.val, t.sat, t.chunk, t.len, t.cause, t.last);
            $display("%0t:          actual kind %0d reg %0d val %h sat %b chunk %h len %0d cause %0d last %b",
                     $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[66:4],
                     m_axis_tdata[67], m_axis_tdata[131:68], m_axis_tdata[137:132],
                     m_axis_tdata[139:138], m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    errors = 0;
    burst_left = 0;
    hold_end = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    scan_mode = MODE_IDLE;
    id_count = 0;
    accum = '0;
    digits = 0;
    stopped = 0;
    sat_flag = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords_and_registers();
    test_numbers();
    test_errors_and_long_idents();
    test_random_stream();
    test_output_hold_off();
    test_after_drain();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && token_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
